>>> rtl/core/bounded_list_stack_search_core_assert.svh
// Assertion macros shared by the list core.
`ifndef BOUNDED_LIST_STACK_SEARCH_CORE_ASSERT_SVH
`define BOUNDED_LIST_STACK_SEARCH_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define BLSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is held.
`define BLSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/blss_pkg.sv
// Shared types and constants for the bounded list core.
`default_nettype none
package blss_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACT_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Per-cell control: compare against the incoming key, or shift.
    typedef struct packed {
        logic cmp_en;
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/core/blss_cell.sv
// One list cell: holds an entry, its registered match flag and the hit chain.
`default_nettype none
module blss_cell #(
    parameter int DATA_WIDTH = blss_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire blss_pkg::t_cell_ctl   i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_cmp_key,
    input  wire logic [DATA_WIDTH-1:0] i_prev_data,
    input  wire logic [DATA_WIDTH-1:0] i_next_data,
    input  wire logic                  i_live,
    input  wire logic                  i_seen,
    output logic [DATA_WIDTH-1:0]      o_data,
    output logic                       o_seen,
    output logic                       o_first
);
    import blss_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_match;
    logic                  w_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_prev) begin
            r_data <= i_prev_data;
        end else if (i_ctl.take_next) begin
            r_data <= i_next_data;
        end
        if (i_ctl.cmp_en) begin
            r_match <= (r_data == i_cmp_key);
        end
    end

    // Only cells below the fill count can hit; the seen flag marks the
    // first hit and every cell after it.
    assign w_hit   = r_match & i_live;
    assign o_seen  = i_seen | w_hit;
    assign o_first = w_hit & ~i_seen;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> rtl/core/bounded_list_stack_search_core.sv
// Bounded list core: push/pop at the head, find, remove and clear.
// A result is registered when the apply state proceeds, which it does only once
// the previous result has been taken; a new transaction is accepted only in idle. The cells
// register their key compare in the accept cycle and shift when the apply step proceeds.
// Reset (synchronous, active low) empties the list and drops any pending result;
// entry contents are not cleared and are never read past the fill count.
`default_nettype none
`include "bounded_list_stack_search_core_assert.svh"
module bounded_list_stack_search_core #(
    parameter int DEPTH      = blss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = blss_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // item_value[31:0]
    input  wire logic [blss_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action[2:0]
    input  wire logic [blss_pkg::ACT_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // out_value[31:0], out_index[36:32], out_count[41:37], zero[47:42]
    output logic [blss_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // out_status[1:0]
    output logic [blss_pkg::STATUS_W-1:0]       o_m_tuser
);
    import blss_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PAD_W = M_TDATA_W - VALUE_W - INDEX_W - COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state                r_state;
    t_action               r_act;
    logic [DATA_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_count;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic [INDEX_W-1:0]    r_out_index;
    logic [COUNT_W-1:0]    r_out_count;
    t_status               r_out_status;

    logic [CNT_W-1:0]      n_count;
    logic [VALUE_W-1:0]    n_value;
    logic [INDEX_W-1:0]    n_index;
    t_status               n_status;

    logic                  w_accept;
    logic                  w_go;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_any_hit;
    logic                  w_push_ok;
    logic                  w_pop_ok;
    logic                  w_remove_ok;
    logic [IDX_W-1:0]      w_first_idx;
    logic [DATA_WIDTH-1:0] w_cmp_key;

    t_cell_ctl             w_ctl   [DEPTH];
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic [DATA_WIDTH-1:0] w_prev  [DEPTH];
    logic [DATA_WIDTH-1:0] w_next  [DEPTH];
    logic [DEPTH-1:0]      w_live;
    logic [DEPTH-1:0]      w_seen;
    logic [DEPTH-1:0]      w_seen_in;
    logic [DEPTH-1:0]      w_first;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_go       = (r_state == S_APPLY) & (~r_out_valid | i_m_tready);
    assign w_cmp_key  = DATA_WIDTH'(i_s_tdata);

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_any_hit   = w_seen[DEPTH-1];
    assign w_push_ok   = (r_act == ACT_PUSH) & ~w_full;
    assign w_pop_ok    = (r_act == ACT_POP) & ~w_empty;
    assign w_remove_ok = (r_act == ACT_REMOVE) & w_any_hit;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign w_live[g]    = (CNT_W'(g) < r_count);
            assign w_prev[g]    = (g == 0) ? r_key : w_data[(g == 0) ? 0 : g - 1];
            assign w_next[g]    = (g == DEPTH - 1) ? w_data[g]
                                                   : w_data[(g == DEPTH - 1) ? g : g + 1];
            assign w_seen_in[g] = (g == 0) ? 1'b0 : w_seen[(g == 0) ? 0 : g - 1];

            // A remove shifts the matching cell and every cell after it.
            assign w_ctl[g].cmp_en    = w_accept;
            assign w_ctl[g].take_prev = w_go & w_push_ok;
            assign w_ctl[g].take_next = w_go & (w_pop_ok | (w_remove_ok & w_seen[g]));

            blss_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[g]),
                .i_cmp_key   (w_cmp_key),
                .i_prev_data (w_prev[g]),
                .i_next_data (w_next[g]),
                .i_live      (w_live[g]),
                .i_seen      (w_seen_in[g]),
                .o_data      (w_data[g]),
                .o_seen      (w_seen[g]),
                .o_first     (w_first[g])
            );
        end
    endgenerate

    // At most one cell flags the first hit, so an OR of positions encodes it.
    always_comb begin
        w_first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_first_idx = w_first_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_value  = '0;
        n_index  = '1;
        n_status = ST_OK;
        case (r_act)
            ACT_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value = VALUE_W'(w_data[0]);
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_FIND: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_any_hit) begin
                    n_status = ST_MISSING;
                end else begin
                    n_index = INDEX_W'(w_first_idx);
                end
            end
            ACT_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_any_hit) begin
                    n_status = ST_MISSING;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= t_action'(i_s_tuser);
            r_key <= w_cmp_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_go) begin
                r_count      <= n_count;
                r_out_valid  <= 1'b1;
                r_out_value  <= n_value;
                r_out_index  <= n_index;
                r_out_count  <= COUNT_W'(n_count);
                r_out_status <= n_status;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_index, r_out_value};
    assign o_m_tuser  = r_out_status;

    `BLSS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count past depth")
    `BLSS_ASSERT(a_first_onehot, i_clk, i_rst_n, $onehot0(w_first), "several first hits")
    `BLSS_ASSERT(a_accept_then_apply, i_clk, i_rst_n,
                 w_accept |=> (r_state == S_APPLY && !o_s_tready),
                 "no apply after accept")
    `BLSS_ASSERT(a_full_count, i_clk, i_rst_n,
                 (w_go && r_act == ACT_PUSH && w_full) |=>
                     (r_out_status == ST_FULL && r_count == CNT_W'(DEPTH)),
                 "full push changed count")

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the bounded list core: push, pop, find, remove and clear.
`timescale 1ns / 100ps
module testbench;
    import blss_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;
    localparam logic [INDEX_W-1:0] NO_INDEX = '1;

    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_ABSENT = 32'h5A5A_0F0F;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_list_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACT_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Predictor state: list_mem[0] is the head.
    logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;
    logic [VALUE_W-1:0] value_pool [8];

    t_list_result expected_results [$];
    int fail_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int ready_phase = 0;

    bounded_list_stack_search_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Remove the entry at pos and close the gap behind it.
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_list_result predict_list_op(input logic [ACT_W-1:0] act,
                                                     input logic [VALUE_W-1:0] val);
        t_list_result r;
        int i;
        int pos;
        r.value  = '0;
        r.index  = NO_INDEX;
        r.status = ST_OK;
        pos = -1;
        case (act)
            ACT_PUSH: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > 0; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[0] = val;
                    list_len++;
                end
            end
            ACT_POP: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = list_mem[0];
                    drop_entry(0);
                end
            end
            ACT_FIND, ACT_REMOVE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 0; i < list_len && pos < 0; i++) begin
                        if (list_mem[i] == val) pos = i;
                    end
                    if (pos < 0) begin
                        r.status = ST_MISSING;
                    end else if (act == ACT_FIND) begin
                        r.index = pos[INDEX_W-1:0];
                    end else begin
                        drop_entry(pos);
                    end
                end
            end
            ACT_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one item in the sender's burst pattern and records its expected result.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(predict_list_op(act, val));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if (list_len > 0 && $urandom_range(0, 1) == 0) begin
            return list_mem[$urandom_range(0, list_len - 1)];
        end
        if ($urandom_range(0, 1) == 0) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_item(ACT_POP, VAL_MAX);
        send_item(ACT_FIND, VAL_ZERO);
        send_item(ACT_REMOVE, VAL_ONES);
        send_item(ACT_CLEAR, VAL_MIN);
        send_item(ACT_UNUSED_FIRST, VAL_ONES);
    endtask

    task automatic test_full_list();
        int i;
        logic [VALUE_W-1:0] v;
        for (i = 0; i < LIST_DEPTH; i++) begin
            case (i)
                0: v = VAL_MIN;
                1, 9: v = VAL_MAX;
                2: v = VAL_ZERO;
                3: v = VAL_ONES;
                default: v = $urandom;
            endcase
            send_item(ACT_PUSH, v);
        end
        send_item(ACT_PUSH, VAL_ZERO);
        // The later duplicate sits nearer the head and must win the search.
        send_item(ACT_FIND, VAL_MAX);
        send_item(ACT_FIND, VAL_MIN);
        send_item(ACT_FIND, VAL_ABSENT);
        send_item(ACT_REMOVE, VAL_MAX);
        send_item(ACT_REMOVE, VAL_MIN);
        send_item(ACT_POP, VAL_ZERO);
        send_item(ACT_CLEAR, VAL_ONES);
    endtask

    // push_share out of 61 sets how fast the list drifts toward full.
    task automatic test_random_traffic(input int n_items, input int push_share);
        int k;
        int r;
        logic [ACT_W-1:0] act;
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2) act = ACT_CLEAR;
            else if (r < 4) act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            else if (r < 24) act = ACT_FIND;
            else if (r < 39) act = ACT_REMOVE;
            else if ($urandom_range(0, 60) < push_share) act = ACT_PUSH;
            else act = ACT_POP;
            send_item(act, pick_value());
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk) begin
        t_list_result exp_r;
        t_list_result got_r;
        if (rst_n && m_tvalid && m_tready) begin
            got_r.value  = m_tdata[31:0];
            got_r.index  = m_tdata[36:32];
            got_r.count  = m_tdata[41:37];
            got_r.status = t_status'(m_tuser);
            if (expected_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: value=%h index=%0d count=%0d status=%0d",
                             got_r.value, got_r.index, got_r.count, got_r.status);
                end
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got_r.value !== exp_r.value || got_r.index !== exp_r.index ||
                    got_r.count !== exp_r.count || got_r.status !== exp_r.status ||
                    m_tdata[47:42] !== '0) begin
                    if (fail_count < 10) begin
                        $display("expected value=%h index=%0d count=%0d status=%0d",
                                 exp_r.value, exp_r.index, exp_r.count, exp_r.status);
                        $display("actual   value=%h index=%0d count=%0d status=%0d pad=%h",
                                 got_r.value, got_r.index, got_r.count, got_r.status,
                                 m_tdata[47:42]);
                    end
                    fail_count++;
                end
            end
        end
        if (ready_mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(16, 200);
        end
        ready_mode_left--;
        ready_phase++;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_phase % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Watchdog: ends the run if no transaction happens on either side for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bounded_list_stack_search_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int i;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = VAL_ZERO;
        value_pool[3] = VAL_ONES;
        for (i = 4; i < 8; i++) value_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        wait_drained();
        test_random_traffic(450, 45);
        wait_drained();
        test_random_traffic(450, 30);
        wait_drained();
        test_random_traffic(450, 15);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("bounded_list_stack_search_core: match");
        end else begin
            $display("bounded_list_stack_search_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/blss_pkg.sv
rtl/core/blss_cell.sv
rtl/core/bounded_list_stack_search_core.sv
bench/testbench.sv
